// File: hw/rtl/clas_pkg.sv
// ----------------------------------------------------------------------------
// clas_pkg
// Shared types and character codes for the command line argument splitter.
// ----------------------------------------------------------------------------
package clas_pkg;

  localparam int RUN_COUNT_BITS_DEF = 16;
  localparam int CHAR_BITS          = 16;

  localparam logic [CHAR_BITS-1:0] CH_BSL   = 16'h005C;
  localparam logic [CHAR_BITS-1:0] CH_QUOTE = 16'h0022;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 16'h0020;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 16'h0009;

  // result kinds
  localparam logic KIND_CHARS = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // quote counter codes
  localparam logic [1:0] QC_OUTSIDE = 2'd0;
  localparam logic [1:0] QC_TRIPLE  = 2'd3;
  localparam logic [1:0] QC_PENDING = 2'd2;

  typedef struct packed {
    logic                 kind;
    logic [CHAR_BITS-1:0] out_char;
    logic [CHAR_BITS-1:0] repeat_res;
  } res_t;

endpackage

// File: hw/rtl/command_line_argument_splitter.sv
// ----------------------------------------------------------------------------
// command_line_argument_splitter
// Splits a stream of 16-bit command line characters into argument runs and
// end-of-argument marks, following the classic runtime quoting rules.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser   | tlast
//  s_      | in  | ch                             | at_end  | -
//  m_      | out | out_char [15:0], repeat [31:16]| kind    | last_of_step
//
//  Each request is decoded combinationally into zero, one or two results,
//  which land in a two-entry result buffer. One result leaves per cycle
//  while m_tready is high; a request yields two results when it gives a held
//  backslash run plus a character or end mark.
//  Reset (rst, synchronous) clears the parser state and empties the buffer.
//  s_tready is high when the buffer is empty or its last entry leaves now.
// ----------------------------------------------------------------------------
module command_line_argument_splitter #(
  parameter int RUN_COUNT_BITS = clas_pkg::RUN_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] ch
  input  logic        s_tuser,   // [0] at_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] out_char, [31:16] repeat_res
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast    // last_of_step
);
  import clas_pkg::*;

  localparam int RW = RUN_COUNT_BITS;

  // parser state
  logic [1:0]    quote_count, quote_count_next;
  logic [RW-1:0] backslash_run, backslash_run_next;
  logic          in_quote_run, in_quote_run_next;
  logic          in_argument, in_argument_next;

  // result buffer: slot0 is at the output
  res_t          slot0, slot1;
  logic [1:0]    fill;

  // decoded results of the current request
  logic          pre_vld;       // held backslash run goes first
  logic [RW-1:0] pre_cnt;
  logic          main_vld;
  res_t          main_res;
  res_t          pre_res;
  logic [1:0]    nres;
  logic          is_blank;
  logic          accept, pop;

  function automatic logic [CHAR_BITS-1:0] clip16(input logic [RW-1:0] v);
    logic [CHAR_BITS-1:0] r;
    if ((RW > CHAR_BITS) && ((v >> CHAR_BITS) != '0)) r = '1;
    else r = CHAR_BITS'(v);
    return r;
  endfunction

  always_comb begin
    quote_count_next   = quote_count;
    backslash_run_next = backslash_run;
    in_quote_run_next  = in_quote_run;
    in_argument_next   = in_argument;
    pre_vld            = 1'b0;
    pre_cnt            = backslash_run;
    main_vld           = 1'b0;
    main_res           = '{kind: KIND_END, out_char: '0, repeat_res: '0};
    is_blank           = (s_tdata == CH_SPACE) || (s_tdata == CH_TAB);

    if (s_tuser) begin
      if (in_argument) begin
        pre_vld  = (backslash_run != '0);
        main_vld = 1'b1;
      end
      quote_count_next   = QC_OUTSIDE;
      backslash_run_next = '0;
      in_quote_run_next  = 1'b0;
      in_argument_next   = 1'b0;
    end else begin
      // a quote run ends: a pending count falls back to outside
      if (in_quote_run && s_tdata != CH_QUOTE) begin
        if (quote_count == QC_PENDING) quote_count_next = QC_OUTSIDE;
        in_quote_run_next = 1'b0;
      end
      if (in_argument || !is_blank) begin
        in_argument_next = 1'b1;
        if (s_tdata == CH_BSL) begin
          if (!(&backslash_run)) backslash_run_next = backslash_run + 1'b1;
        end else if (s_tdata == CH_QUOTE) begin
          if (in_quote_run) begin
            if (quote_count + 2'd1 == QC_TRIPLE) begin
              main_vld         = 1'b1;
              main_res         = '{kind: KIND_CHARS, out_char: CH_QUOTE, repeat_res: 16'd1};
              quote_count_next = QC_OUTSIDE;
            end else begin
              quote_count_next = quote_count + 2'd1;
            end
          end else begin
            pre_cnt = backslash_run >> 1;
            pre_vld = (pre_cnt != '0);
            if (!backslash_run[0]) begin
              quote_count_next = quote_count + 2'd1;
            end else begin
              main_vld = 1'b1;
              main_res = '{kind: KIND_CHARS, out_char: CH_QUOTE, repeat_res: 16'd1};
            end
          end
          backslash_run_next = '0;
          in_quote_run_next  = 1'b1;
        end else if (is_blank && quote_count_next == QC_OUTSIDE) begin
          pre_vld            = (backslash_run != '0);
          main_vld           = 1'b1;
          backslash_run_next = '0;
          in_argument_next   = 1'b0;
        end else begin
          pre_vld            = (backslash_run != '0);
          main_vld           = 1'b1;
          main_res           = '{kind: KIND_CHARS, out_char: s_tdata, repeat_res: 16'd1};
          backslash_run_next = '0;
        end
      end
    end

    pre_res = '{kind: KIND_CHARS, out_char: CH_BSL, repeat_res: clip16(pre_cnt)};
    nres    = {1'b0, pre_vld} + {1'b0, main_vld};
  end

  assign m_tvalid = (fill != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (fill == 2'd0) || (fill == 2'd1 && m_tready);
  assign accept   = s_tvalid && s_tready;

  assign m_tdata  = {slot0.repeat_res, slot0.out_char};
  assign m_tuser  = slot0.kind;
  assign m_tlast  = (fill == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_count   <= QC_OUTSIDE;
      backslash_run <= '0;
      in_quote_run  <= 1'b0;
      in_argument   <= 1'b0;
      fill          <= 2'd0;
    end else begin
      if (accept) begin
        quote_count   <= quote_count_next;
        backslash_run <= backslash_run_next;
        in_quote_run  <= in_quote_run_next;
        in_argument   <= in_argument_next;
        fill          <= nres;
      end else if (pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      slot0 <= pre_vld ? pre_res : main_res;
      slot1 <= main_res;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  // --------------------------------------------------------------------------
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while buffer cannot drain");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("result buffer overfilled");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser |=> !in_argument && backslash_run == '0
      && quote_count == QC_OUTSIDE && !in_quote_run)
    else $error("state not cleared after end marker");

  a_results_show: assert property (@(posedge clk) disable iff (rst)
    accept && nres != 2'd0 |=> m_tvalid)
    else $error("decoded result not presented");

  a_quote_count: assert property (@(posedge clk) disable iff (rst)
    quote_count != QC_TRIPLE)
    else $error("quote counter left at three");

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the command line argument splitter: streams command
// lines in, predicts every argument piece in step, compares the output stream.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clas_pkg::*;

  // one request on the input stream
  typedef struct {
    logic [15:0] ch;
    logic        at_end;
    int unsigned gap;     // idle cycles the sender leaves after this request
  } cmd_req_t;

  // one piece of an argument as the block reports it
  typedef struct {
    logic        kind;
    logic [15:0] chr;
    logic [15:0] count;
    logic        last;
  } arg_piece_t;

  // backslash run counter saturates here (default run width is 16 bits)
  localparam logic [15:0] RUN_SAT = 16'hFFFF;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;     // [15:0] ch
  logic        s_tuser  = 1'b0;   // [0] at_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [15:0] out_char, [31:16] repeat_res
  logic        m_tuser;           // [0] kind
  logic        m_tlast;           // last_of_step

  command_line_argument_splitter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL command_line_argument_splitter");
    $finish;
  end

  cmd_req_t   cmdline_q[$];     // requests not yet offered
  arg_piece_t pieces_due[$];    // predicted pieces not yet seen
  int unsigned bad_count = 0;

  // ---------------------------------------------------------------------------
  // Splitter state as the predictor tracks it
  // ---------------------------------------------------------------------------
  logic [1:0]  quote_cnt  = QC_OUTSIDE;  // 0 outside, 1 inside, 2 pending close
  logic [15:0] bsl_run    = '0;          // held backslashes
  bit          quote_run  = 1'b0;        // previous char was a quote
  bit          in_arg     = 1'b0;        // an argument has begun

  task automatic add_piece(input logic kind, input logic [15:0] c, input logic [15:0] n);
    arg_piece_t p;
    p.kind  = kind;
    p.chr   = c;
    p.count = n;
    p.last  = 1'b0;
    pieces_due.push_back(p);
  endtask

  // held backslashes are only reported when there is at least one
  task automatic add_bsl_run(input logic [15:0] n);
    if (n != 0)
      add_piece(KIND_CHARS, CH_BSL, n);
  endtask

  // advance the predicted splitter by one request, queue what it reports
  task automatic split_char(input logic [15:0] c, input logic at_end);
    int unsigned n0;
    logic        blank;
    arg_piece_t  tail;
    n0 = pieces_due.size();
    if (at_end) begin
      // close an open argument, even an empty one; nothing outside
      if (in_arg) begin
        add_bsl_run(bsl_run);
        add_piece(KIND_END, '0, '0);
      end
      quote_cnt = QC_OUTSIDE;
      bsl_run   = '0;
      quote_run = 1'b0;
      in_arg    = 1'b0;
    end else begin
      // a quote run that ends with a pending close drops back outside
      if (quote_run && c != CH_QUOTE) begin
        if (quote_cnt == QC_PENDING)
          quote_cnt = QC_OUTSIDE;
        quote_run = 1'b0;
      end
      blank = (c == CH_SPACE || c == CH_TAB);
      // leading and repeated blanks are skipped
      if (in_arg || !blank) begin
        in_arg = 1'b1;
        if (c == CH_BSL) begin
          if (bsl_run != RUN_SAT)
            bsl_run = bsl_run + 16'd1;
        end else if (c == CH_QUOTE) begin
          if (quote_run) begin
            // every third quote of a run stands as a literal
            quote_cnt = quote_cnt + 2'd1;
            if (quote_cnt == QC_TRIPLE) begin
              add_piece(KIND_CHARS, CH_QUOTE, 16'd1);
              quote_cnt = QC_OUTSIDE;
            end
          end else if (!bsl_run[0]) begin
            // even run: half the backslashes, quote toggles quoting
            add_bsl_run(bsl_run >> 1);
            quote_cnt = quote_cnt + 2'd1;
          end else begin
            // odd run: half the backslashes, then a literal quote
            add_bsl_run(bsl_run >> 1);
            add_piece(KIND_CHARS, CH_QUOTE, 16'd1);
          end
          bsl_run   = '0;
          quote_run = 1'b1;
        end else if (blank && quote_cnt == QC_OUTSIDE) begin
          add_bsl_run(bsl_run);
          add_piece(KIND_END, '0, '0);
          bsl_run = '0;
          in_arg  = 1'b0;
        end else begin
          add_bsl_run(bsl_run);
          add_piece(KIND_CHARS, c, 16'd1);
          bsl_run = '0;
        end
      end
    end
    // flag the final piece of this request
    if (pieces_due.size() > n0) begin
      tail      = pieces_due.pop_back();
      tail.last = 1'b1;
      pieces_due.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // character mix weighted toward the quoting rules
  function automatic logic [15:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 22)
      return CH_BSL;
    if (r < 40)
      return CH_QUOTE;
    if (r < 52)
      return CH_SPACE;
    if (r < 57)
      return CH_TAB;
    if (r < 80)
      return 16'h0061 + 16'($urandom_range(0, 25));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic push_ch(input logic [15:0] c, input int unsigned gap);
    cmd_req_t q;
    q.ch     = c;
    q.at_end = 1'b0;
    q.gap    = gap;
    cmdline_q.push_back(q);
  endtask

  // the character lane of an end marker is don't-care: fill it randomly
  task automatic push_end(input int unsigned gap);
    cmd_req_t q;
    q.ch     = 16'($urandom_range(0, 65535));
    q.at_end = 1'b1;
    q.gap    = gap;
    cmdline_q.push_back(q);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_ch({8'h00, s[i]}, pick_gap(1'b1));
  endtask

  // one random command line closed by an end marker; fed counts the requests
  // that the block acts on (leading blanks are not counted)
  task automatic push_line(input bit idle, inout int unsigned fed);
    int unsigned len;
    logic [15:0] c;
    bit          begun;
    len   = $urandom_range(0, 24);
    begun = 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      c = pick_char();
      if (c != CH_SPACE && c != CH_TAB)
        begun = 1'b1;
      if (begun)
        fed++;
      push_ch(c, pick_gap(idle));
    end
    push_end(pick_gap(idle));
    fed++;
    // a stray end marker now and then: must give nothing
    if ($urandom_range(0, 9) == 0)
      push_end(pick_gap(idle));
  endtask

  task automatic wait_drained();
    while (cmdline_q.size() != 0 || s_tvalid || pieces_due.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers queued requests, predicts each one as it is taken
  // ---------------------------------------------------------------------------
  int unsigned send_gap = 0;
  cmd_req_t    nxt_req;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready)
        split_char(s_tdata, s_tuser);
      // a new request may go out once the current one is taken
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (cmdline_q.size() != 0) begin
          nxt_req = cmdline_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt_req.ch;
          s_tuser  <= nxt_req.at_end;
          send_gap = nxt_req.gap;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, one long hold on request, checks pieces
  // ---------------------------------------------------------------------------
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned rx_gap   = 0;
  bit          rx_idle  = 1'b1;
  arg_piece_t  want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap   = 0;
      hold_cnt = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pieces_due.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected piece kind=%0d char=%h count=%0d last=%0d",
                     $realtime, m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast);
        end else begin
          want = pieces_due.pop_front();
          if (m_tuser !== want.kind || m_tdata[15:0] !== want.chr ||
              m_tdata[31:16] !== want.count || m_tlast !== want.last) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: exp k=%0d c=%h n=%0d l=%0d got k=%0d c=%h n=%0d l=%0d",
                       $realtime, want.kind, want.chr, want.count, want.last,
                       m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast);
          end
        end
        rx_gap = pick_gap(rx_idle);
        // switch between stalling and free-running stretches
        if ($urandom_range(0, 39) == 0)
          rx_idle = !rx_idle;
      end else if (rx_gap != 0) begin
        rx_gap = rx_gap - 1;
      end
      if (hold_req) begin
        hold_cnt = 400;
        hold_req = 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt = hold_cnt - 1;
      end
      m_tready <= (rx_gap == 0 && hold_cnt == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned fed;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: end marker with nothing open, leading blanks, characters 0 and
    // FFFF, odd and even backslash runs before a quote, blank inside quotes,
    // triple quotes, tab inside quotes, empty argument, open quote with a
    // trailing blank at end, backslash held at end
    push_end(0);
    push_text(" \t");
    push_ch(16'h0000, 0);
    push_ch(16'hFFFF, 0);
    push_text("\\\\\\\"\\\\\" \"\"\"b\t\"\"");
    push_text(" \"\"");
    push_end(1);
    push_text("\" ");
    push_end(0);
    push_text("\\");
    push_end(2);
    wait_drained();

    // random lines, idling switched per line
    fed = 0;
    while (fed < 250)
      push_line($urandom_range(0, 3) != 0, fed);

    // sender pause until every piece is back
    wait_drained();

    // receiver holds off while the sender streams back to back
    hold_req = 1'b1;
    fed = 0;
    while (fed < 60)
      push_line(1'b0, fed);
    while (fed < 250)
      push_line($urandom_range(0, 3) != 0, fed);

    fed = 0;
    while (fed < 250)
      push_line($urandom_range(0, 3) != 0, fed);

    wait_drained();
    repeat (12) @(negedge clk);
    if (bad_count == 0 && pieces_due.size() == 0)
      $display("PASS command_line_argument_splitter");
    else
      $display("FAIL command_line_argument_splitter");
    $finish;
  end

endmodule
